// File: design/rrs_pkg.sv
package rrs_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W         = $clog2(MAX_PROCESSES);
    localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
    localparam int BURST_W       = 12;
    localparam int TIME_W        = 16;
    localparam int QUANT_W       = 8;
    localparam int PIDX_W        = 4;

    // microprogram address
    typedef logic [2:0] t_upc;

    localparam t_upc UA_LOAD   = 3'd0;
    localparam t_upc UA_PASS   = 3'd1;
    localparam t_upc UA_RD_REM = 3'd2;
    localparam t_upc UA_SERVE  = 3'd3;
    localparam t_upc UA_TEST   = 3'd4;
    localparam t_upc UA_EMIT0  = 3'd5;
    localparam t_upc UA_RD_RES = 3'd6;
    localparam t_upc UA_EMIT   = 3'd7;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_CLR    = 3'd2,
        OP_RD_REM = 3'd3,
        OP_SERVE  = 3'd4,
        OP_RD_RES = 3'd5,
        OP_EMIT   = 3'd6
    } t_op;

    // condition under which a step completes; otherwise it holds
    typedef enum logic [1:0] {
        GO_ALWAYS   = 2'd0,
        GO_IN_XFER  = 2'd1,
        GO_OUT_FREE = 2'd2
    } t_go;

    typedef enum logic [1:0] {
        J_NEVER    = 2'd0,
        J_CLOSE    = 2'd1,
        J_LAST_IDX = 2'd2,
        J_BUSY     = 2'd3
    } t_jmp;

    typedef struct packed {
        t_op  op;
        t_go  go;
        t_jmp jmp;
        t_upc jmp_to;
        t_upc seq_to;
    } t_uword;

    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        unique case (a)
            UA_LOAD:   w = '{OP_LOAD,   GO_IN_XFER,  J_CLOSE,    UA_PASS,  UA_LOAD};
            UA_PASS:   w = '{OP_CLR,    GO_ALWAYS,   J_NEVER,    UA_PASS,  UA_RD_REM};
            UA_RD_REM: w = '{OP_RD_REM, GO_ALWAYS,   J_NEVER,    UA_PASS,  UA_SERVE};
            UA_SERVE:  w = '{OP_SERVE,  GO_ALWAYS,   J_LAST_IDX, UA_TEST,  UA_RD_REM};
            UA_TEST:   w = '{OP_NONE,   GO_ALWAYS,   J_BUSY,     UA_PASS,  UA_EMIT0};
            UA_EMIT0:  w = '{OP_CLR,    GO_ALWAYS,   J_NEVER,    UA_PASS,  UA_RD_RES};
            UA_RD_RES: w = '{OP_RD_RES, GO_ALWAYS,   J_NEVER,    UA_PASS,  UA_EMIT};
            UA_EMIT:   w = '{OP_EMIT,   GO_OUT_FREE, J_LAST_IDX, UA_LOAD,  UA_RD_RES};
            default:   w = '{OP_NONE,   GO_ALWAYS,   J_NEVER,    UA_LOAD,  UA_LOAD};
        endcase
        return w;
    endfunction

endpackage

// File: design/round_robin_schedule_sim.sv
// Round-robin schedule simulator. Jobs are loaded one per transfer until a job
// with i_last_process set (or the one filling the last of MAX_PROCESSES slots)
// closes the set. A short microprogram then runs passes over the jobs, each job
// taking a registered read of the remaining time, then an update; a pass ends
// in a busy test that starts another pass while any job has time left. Results
// then leave in load order, each read from the stores and then written to the
// output register, holding while the output is stalled. No input is taken
// between the closing job and the final result's hand-off to the output
// register. The quantum is written through the config channel, always ready;
// a quantum of zero acts as one.
module round_robin_schedule_sim (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rrs_pkg::QUANT_W-1:0]   i_cfg_time_quantum,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rrs_pkg::BURST_W-1:0]   i_burst_time,
    input  logic                          i_last_process,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rrs_pkg::PIDX_W-1:0]    o_process_index,
    output logic [rrs_pkg::TIME_W-1:0]    o_turnaround_time,
    output logic [rrs_pkg::TIME_W-1:0]    o_wait_time,
    output logic                          o_last_result
);
    import rrs_pkg::*;

    // sequencer
    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   go, take_jump, close, last_idx;

    // datapath control state
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_busy, n_busy;
    logic [TIME_W-1:0]  r_clock, n_clock;
    logic [QUANT_W-1:0] r_quantum;
    logic               r_out_valid, n_out_valid;

    // job stores
    logic [BURST_W-1:0] r_burst_mem [MAX_PROCESSES];
    logic [BURST_W-1:0] r_rem_mem   [MAX_PROCESSES];
    logic [TIME_W-1:0]  r_fin_mem   [MAX_PROCESSES];
    logic [BURST_W-1:0] r_rem_rd, r_burst_rd;
    logic [TIME_W-1:0]  r_fin_rd;

    // output register
    logic [PIDX_W-1:0]  r_out_idx;
    logic [TIME_W-1:0]  r_out_tat, r_out_wait;
    logic               r_out_last;

    // serve arithmetic
    logic [BURST_W-1:0] quant, slice, new_rem;
    logic [TIME_W-1:0]  new_clock;
    logic               rem_nz, do_load, do_serve, do_emit, out_free;

    assign uw       = ucode(r_upc);
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_idx = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign close    = i_last_process || (r_count == CNT_W'(MAX_PROCESSES - 1));

    always_comb begin
        unique case (uw.go)
            GO_ALWAYS:   go = 1'b1;
            GO_IN_XFER:  go = i_in_valid;
            GO_OUT_FREE: go = out_free;
            default:     go = 1'b0;
        endcase
        unique case (uw.jmp)
            J_NEVER:    take_jump = 1'b0;
            J_CLOSE:    take_jump = close;
            J_LAST_IDX: take_jump = last_idx;
            J_BUSY:     take_jump = r_busy;
            default:    take_jump = 1'b0;
        endcase
        n_upc = go ? (take_jump ? uw.jmp_to : uw.seq_to) : r_upc;
    end

    assign do_load  = (uw.op == OP_LOAD) && go;
    assign do_serve = (uw.op == OP_SERVE);
    assign do_emit  = (uw.op == OP_EMIT) && go;

    assign quant     = (r_quantum == '0) ? BURST_W'(1) : BURST_W'(r_quantum);
    assign rem_nz    = r_rem_rd != '0;
    assign slice     = (r_rem_rd < quant) ? r_rem_rd : quant;
    assign new_rem   = r_rem_rd - slice;
    assign new_clock = r_clock + TIME_W'(slice);

    always_comb begin
        n_idx       = r_idx;
        n_count     = r_count;
        n_busy      = r_busy;
        n_clock     = r_clock;
        n_out_valid = r_out_valid && i_out_stall;
        if (uw.op == OP_CLR) begin
            n_idx  = '0;
            n_busy = 1'b0;
        end
        if (do_load) begin
            n_count = r_count + CNT_W'(1);
            if (close) begin
                n_clock = '0;
            end
        end
        if (do_serve) begin
            n_idx = r_idx + IDX_W'(1);
            if (rem_nz) begin
                n_clock = new_clock;
                if (new_rem != '0) begin
                    n_busy = 1'b1;
                end
            end
        end
        if (do_emit) begin
            n_idx       = r_idx + IDX_W'(1);
            n_out_valid = 1'b1;
            if (last_idx) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UA_LOAD;
            r_idx       <= '0;
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_clock     <= '0;
            r_quantum   <= QUANT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_busy      <= n_busy;
            r_clock     <= n_clock;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_quantum <= i_cfg_time_quantum;
            end
        end
    end

    // stores: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_burst_mem[r_count[IDX_W-1:0]] <= i_burst_time;
        end
        if (uw.op == OP_RD_RES) begin
            r_burst_rd <= r_burst_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_rem_mem[r_count[IDX_W-1:0]] <= i_burst_time;
        end else if (do_serve && rem_nz) begin
            r_rem_mem[r_idx] <= new_rem;
        end
        if (uw.op == OP_RD_REM) begin
            r_rem_rd <= r_rem_mem[r_idx];
        end
    end

    // a zero burst is never served, so its finish time stays at the loaded zero
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_fin_mem[r_count[IDX_W-1:0]] <= '0;
        end else if (do_serve && rem_nz && (new_rem == '0)) begin
            r_fin_mem[r_idx] <= new_clock;
        end
        if (uw.op == OP_RD_RES) begin
            r_fin_rd <= r_fin_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out_idx  <= PIDX_W'(r_idx);
            r_out_tat  <= r_fin_rd;
            r_out_wait <= r_fin_rd - TIME_W'(r_burst_rd);
            r_out_last <= last_idx;
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_in_stall        = r_upc != UA_LOAD;
    assign o_out_valid       = r_out_valid;
    assign o_process_index   = r_out_idx;
    assign o_turnaround_time = r_out_tat;
    assign o_wait_time       = r_out_wait;
    assign o_last_result     = r_out_last;

endmodule

// File: design/rrs_checker.sv
module rrs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_stall,
    input logic                        i_last_process,
    input logic                        i_out_valid,
    input logic                        i_out_stall,
    input logic [rrs_pkg::PIDX_W-1:0]  i_process_index,
    input logic [rrs_pkg::TIME_W-1:0]  i_turnaround_time,
    input logic                        i_last_result
);
    import rrs_pkg::*;

    logic in_xfer, out_xfer;

    assign in_xfer  = i_in_valid && !i_in_stall;
    assign out_xfer = i_out_valid && !i_out_stall;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_process_index)
            && $stable(i_turnaround_time) && $stable(i_last_result))
        else $error("stalled result changed");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // closing job starts the run: input blocked next cycle
    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_last_process |=> i_in_stall)
        else $error("input taken right after closing job");

    // more results pending: input stays blocked
    a_emit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !i_last_result |-> i_in_stall)
        else $error("input taken during result emission");

endmodule

bind round_robin_schedule_sim rrs_checker u_rrs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .i_in_stall        (o_in_stall),
    .i_last_process    (i_last_process),
    .i_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .i_process_index   (o_process_index),
    .i_turnaround_time (o_turnaround_time),
    .i_last_result     (o_last_result)
);

// File: tb/sv/round_robin_schedule_sim_tb.sv
module round_robin_schedule_sim_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrs_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int IDLE_PCT    = 37;
    localparam int SHOW_MAX    = 100;

    typedef struct packed {
        logic [PIDX_W-1:0] index;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              is_last;
    } t_sched_result;

    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 i_cfg_valid        = 1'b0;
    logic [QUANT_W-1:0]   i_cfg_time_quantum = '0;
    logic                 i_in_valid         = 1'b0;
    logic [BURST_W-1:0]   i_burst_time       = '0;
    logic                 i_last_process     = 1'b0;
    logic                 i_out_stall        = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [PIDX_W-1:0]    o_process_index;
    logic [TIME_W-1:0]    o_turnaround_time;
    logic [TIME_W-1:0]    o_wait_time;
    logic                 o_last_result;

    t_sched_result        pending_results[$];
    logic [BURST_W-1:0]   open_set_bursts[$];
    logic [QUANT_W-1:0]   quantum_now = 8'd1;
    t_sched_result        seen_result;
    t_sched_result        due_result;
    int                   err_count   = 0;
    int                   cycle_count = 0;
    bit                   calm        = 1'b0;

    round_robin_schedule_sim DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_time_quantum (i_cfg_time_quantum),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_burst_time       (i_burst_time),
        .i_last_process     (i_last_process),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_process_index    (o_process_index),
        .o_turnaround_time  (o_turnaround_time),
        .o_wait_time        (o_wait_time),
        .o_last_result      (o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (err_count < SHOW_MAX)
            $display("mismatch, cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Round-robin service of the closed set; queues one result per job.
    task automatic schedule_set();
        logic [BURST_W-1:0] left [MAX_PROCESSES];
        logic [TIME_W-1:0]  done_at [MAX_PROCESSES];
        logic [TIME_W-1:0]  now_t;
        t_sched_result      r;
        int                 q;
        int                 n;
        int                 slice;
        bit                 busy;
        n = open_set_bursts.size();
        q = (quantum_now == 0) ? 1 : int'(quantum_now);
        now_t = '0;
        for (int i = 0; i < n; i++) begin
            left[i]    = open_set_bursts[i];
            done_at[i] = '0;
        end
        busy = 1'b1;
        while (busy) begin
            busy = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (left[i] != 0) begin
                    slice   = (int'(left[i]) < q) ? int'(left[i]) : q;
                    left[i] = left[i] - BURST_W'(slice);
                    now_t   = now_t + TIME_W'(slice);
                    if (left[i] == 0)
                        done_at[i] = now_t;
                    else
                        busy = 1'b1;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            r.index      = PIDX_W'(i);
            r.turnaround = done_at[i];
            r.waiting    = done_at[i] - TIME_W'(open_set_bursts[i]);
            r.is_last    = (i == n - 1);
            pending_results.push_back(r);
        end
        open_set_bursts.delete();
    endtask

    // Result side: check each transfer, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_result.index      = o_process_index;
            seen_result.turnaround = o_turnaround_time;
            seen_result.waiting    = o_wait_time;
            seen_result.is_last    = o_last_result;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result idx %0d tat %0d wait %0d last %0b",
                    seen_result.index, seen_result.turnaround, seen_result.waiting,
                    seen_result.is_last));
            end else begin
                due_result = pending_results.pop_front();
                if (seen_result !== due_result)
                    report_mismatch($sformatf(
                        "idx %0d/%0d tat %0d/%0d wait %0d/%0d last %0b/%0b (got/exp)",
                        seen_result.index, due_result.index,
                        seen_result.turnaround, due_result.turnaround,
                        seen_result.waiting, due_result.waiting,
                        seen_result.is_last, due_result.is_last));
            end
        end
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send_job(input logic [BURST_W-1:0] burst, input logic is_last);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid     <= 1'b1;
        i_burst_time   <= burst;
        i_last_process <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        open_set_bursts.push_back(burst);
        if (is_last || open_set_bursts.size() == MAX_PROCESSES)
            schedule_set();
    endtask

    // drop the last transfer off the bus before the block goes back to loading
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [QUANT_W-1:0] q);
        wait_idle();
        i_cfg_valid        <= 1'b1;
        i_cfg_time_quantum <= q;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        quantum_now = q;
    endtask

    // Quantum left at its reset value; single-job sets at both burst extremes.
    task automatic test_reset_quantum();
        send_job(12'hFFF, 1'b1);
        send_job(12'h000, 1'b1);
    endtask

    // Sixteen jobs without the flag: the one filling the store closes the set.
    task automatic test_full_store();
        logic [BURST_W-1:0] pattern [MAX_PROCESSES] = '{
            12'hFFF, 12'h000, 12'h001, 12'hAAA, 12'h555, 12'h0FF, 12'h100, 12'h800,
            12'h7FF, 12'h0FE, 12'hF00, 12'h00F, 12'h3C3, 12'hC3C, 12'h002, 12'hFFE};
        write_quantum(8'd255);
        for (int i = 0; i < MAX_PROCESSES; i++)
            send_job(pattern[i], 1'b0);
    endtask

    task automatic test_zero_bursts();
        write_quantum(8'd3);
        send_job(12'd0, 1'b0);
        send_job(12'd7, 1'b0);
        send_job(12'd0, 1'b0);
        send_job(12'd2, 1'b0);
        send_job(12'd0, 1'b1);
    endtask

    // Zero quantum must behave as one.
    task automatic test_quantum_zero();
        write_quantum(8'd0);
        send_job(12'd3, 1'b0);
        send_job(12'd5, 1'b1);
    endtask

    task automatic send_random_set(input bit heavy, output int n);
        logic [BURST_W-1:0] b;
        logic               is_last;
        n = ($urandom_range(7) == 0) ? MAX_PROCESSES : int'($urandom_range(1, MAX_PROCESSES));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                b = '0;
            else if (heavy)
                b = BURST_W'($urandom_range(4095));
            else
                b = BURST_W'($urandom_range(127));
            if (i != n - 1)
                is_last = 1'b0;
            else if (n == MAX_PROCESSES)
                is_last = 1'($urandom_range(1));
            else
                is_last = 1'b1;
            send_job(b, is_last);
        end
    endtask

    // Phases of random sets, a new quantum per phase. Full-range bursts only
    // with larger quanta so that the pass count stays bounded.
    task automatic test_random_sets();
        logic [QUANT_W-1:0] q;
        int                 sent;
        int                 n;
        bit                 heavy;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin
                    q = 8'd1;
                end
                1: begin
                    q = 8'd255;
                end
                default: begin
                    if ($urandom_range(3) == 0)
                        q = QUANT_W'($urandom_range(1, 8));
                    else
                        q = QUANT_W'($urandom_range(1, 255));
                end
            endcase
            write_quantum(q);
            calm = (ph == 2);
            sent = 0;
            while (sent < 32) begin
                heavy = (q >= 16) && ($urandom_range(7) == 0);
                send_random_set(heavy, n);
                sent += n;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_quantum();
        test_full_store();
        test_zero_bursts();
        test_quantum_zero();
        test_random_sets();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
design/rrs_pkg.sv
design/round_robin_schedule_sim.sv
design/rrs_checker.sv
tb/sv/round_robin_schedule_sim_tb.sv
